// ----- rtl/frame_diff_change_rectangle_assert.svh -----
// ----------------------------------------------------------------------------
// frame_diff_change_rectangle assertion macros
// concurrent assertion forms shared by the checker
// ----------------------------------------------------------------------------
`ifndef FRAME_DIFF_CHANGE_RECTANGLE_ASSERT_SVH
`define FRAME_DIFF_CHANGE_RECTANGLE_ASSERT_SVH

// property holds on every clock edge outside reset
`define FDCR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FDCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/fdcr_pkg.sv -----
// ----------------------------------------------------------------------------
// fdcr_pkg
// types and constants of the frame difference change rectangle block
// ----------------------------------------------------------------------------
package fdcr_pkg;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 136;
   localparam int CSR_ADDR_W = 2;

   localparam logic [31:0] MASK_RESET      = 32'hfffefefe;
   localparam logic [31:0] ALPHA_MASK      = 32'hff000000;
   localparam logic [31:0] NOT_OPAQUE_COST = 32'hfffffffe;
   localparam logic [24:0] COUNT_MAX       = 25'h1ffffff;
   localparam logic [23:0] COST_MAX        = 24'hffffff;

   localparam logic [CSR_ADDR_W-1:0] ADDR_COMPARE_MASK = 2'd0;

   typedef struct packed {
      logic [11:0] left;
      logic [12:0] right;
      logic [11:0] top;
      logic [12:0] bottom;
      logic [24:0] count;
      logic        opaque;
   } summary_type;

endpackage

// ----- rtl/fdcr_region.sv -----
// ----------------------------------------------------------------------------
// fdcr_region
// per-pixel change test and running rectangle, count and opacity state
// ----------------------------------------------------------------------------
module fdcr_region
   import fdcr_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] compare_mask,
   input  logic        step,
   input  logic        last,
   input  logic [11:0] pos_x,
   input  logic [11:0] pos_y,
   input  logic [31:0] prev_pixel,
   input  logic [31:0] cur_pixel,
   output summary_type summary
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int BW    = (DIM_W > 13) ? DIM_W : 13;
   localparam logic [BW-1:0] DIM_RESET = BW'(MAX_DIM);

   logic [BW-1:0] min_x_ff, min_x_in;
   logic [BW-1:0] max_x_ff, max_x_in;
   logic [BW-1:0] min_y_ff, min_y_in;
   logic [BW-1:0] max_y_ff, max_y_in;
   logic [24:0]   count_ff, count_in;
   logic          opaque_ff, opaque_in;

   logic          changed;
   logic [BW-1:0] x_ext, y_ext, x_end, y_end;

   always_comb begin
      changed  = |((prev_pixel ^ cur_pixel) & compare_mask);
      x_ext    = BW'(pos_x);
      y_ext    = BW'(pos_y);
      x_end    = x_ext + BW'(1);
      y_end    = y_ext + BW'(1);
      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      count_in = count_ff;
      opaque_in = opaque_ff;
      if (changed) begin
         if (x_ext < min_x_ff) min_x_in = x_ext;
         if (y_ext < min_y_ff) min_y_in = y_ext;
         if (x_end > max_x_ff) max_x_in = x_end;
         if (y_end > max_y_ff) max_y_in = y_end;
         if (count_ff != COUNT_MAX) count_in = count_ff + 25'd1;
         if ((cur_pixel & ALPHA_MASK) != ALPHA_MASK) opaque_in = 1'b0;
      end
      summary.left   = min_x_in[11:0];
      summary.right  = max_x_in[12:0];
      summary.top    = min_y_in[11:0];
      summary.bottom = max_y_in[12:0];
      summary.count  = count_in;
      summary.opaque = opaque_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         min_x_ff  <= DIM_RESET;
         max_x_ff  <= '0;
         min_y_ff  <= DIM_RESET;
         max_y_ff  <= '0;
         count_ff  <= '0;
         opaque_ff <= 1'b1;
      end else if (step) begin
         min_x_ff  <= min_x_in;
         max_x_ff  <= max_x_in;
         min_y_ff  <= min_y_in;
         max_y_ff  <= max_y_in;
         count_ff  <= count_in;
         opaque_ff <= opaque_in;
      end
   end

endmodule

// ----- rtl/frame_diff_change_rectangle.sv -----
// ----------------------------------------------------------------------------
// frame_diff_change_rectangle
// change rectangle, count and blend cost between two frames
// ----------------------------------------------------------------------------
// pixel pairs arrive on the req_ stream, one beat per pair with its column
// and row; tlast marks the final pair of the scan region. the compare mask
// is set through the csr_ apb port; the user must change it only while the
// block is idle, which the block itself does not enforce. no beat without
// tlast gives a result. the tlast beat gives one rsp_ beat with the
// rectangle, change count, opacity flag and the two costs. throughput is
// one pair per cycle while req_tready stays high. a tlast beat in the input
// register moves its summary into the summary stage as the running state
// clears; the area multiply and cost compare then load into the output reg.
// reset restores the mask and clears the running state and the pipeline.
// when the receiver stalls, a finished result waits in the output register,
// a second one in the summary stage, and pairs keep flowing until a third
// tlast beat needs the full summary stage; then req_tready drops.
// ----------------------------------------------------------------------------
module frame_diff_change_rectangle
   import fdcr_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x[11:0], pos_y[23:12], prev_pixel[55:24], cur_pixel[87:56]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // any_change[0], left[12:1], right[25:13], top[37:26], bottom[50:38],
   // changed_count[75:51], all_opaque[76], rect_cost[100:77],
   // blend_cost[132:101], use_over[133], zero[135:134]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [31:0] mask_ff;

   logic        s1_valid_ff;
   logic        s1_last_ff;
   logic [11:0] s1_x_ff;
   logic [11:0] s1_y_ff;
   logic [31:0] s1_prev_ff;
   logic [31:0] s1_cur_ff;

   logic        s2_valid_ff;
   summary_type s2_sum_ff;
   summary_type summary;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic s1_move, s2_move, s2_free;

   logic        any_change;
   logic [12:0] width, height;
   logic [25:0] area, area_m1;
   logic [23:0] rect_cost;
   logic [31:0] blend_cost;
   logic        use_over;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_COMPARE_MASK) ? mask_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == ADDR_COMPARE_MASK) begin
         mask_ff <= csr_pwdata;
      end
   end

   // pipeline flow
   assign s2_move    = s2_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign s2_free    = !s2_valid_ff || s2_move;
   assign s1_move    = s1_valid_ff && (!s1_last_ff || s2_free);
   assign req_tready = !s1_valid_ff || s1_move;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_last_ff <= req_tlast;
         s1_x_ff    <= req_tdata[11:0];
         s1_y_ff    <= req_tdata[23:12];
         s1_prev_ff <= req_tdata[55:24];
         s1_cur_ff  <= req_tdata[87:56];
      end
   end

   fdcr_region #(
      .MAX_DIM (MAX_DIM)
   ) u_region (
      .clock        (clock),
      .reset        (reset),
      .compare_mask (mask_ff),
      .step         (s1_move),
      .last         (s1_last_ff),
      .pos_x        (s1_x_ff),
      .pos_y        (s1_y_ff),
      .prev_pixel   (s1_prev_ff),
      .cur_pixel    (s1_cur_ff),
      .summary      (summary)
   );

   // summary capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_move && s1_last_ff) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_move) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_last_ff) begin
         s2_sum_ff <= summary;
      end
   end

   // costs
   always_comb begin
      any_change = s2_sum_ff.count != 25'd0;
      width      = s2_sum_ff.right - {1'b0, s2_sum_ff.left};
      height     = s2_sum_ff.bottom - {1'b0, s2_sum_ff.top};
      area       = width * height;
      area_m1    = area - 26'd1;
      rect_cost  = (area_m1 > {2'b00, COST_MAX}) ? COST_MAX : area_m1[23:0];
      blend_cost = s2_sum_ff.opaque ? {7'd0, s2_sum_ff.count} : NOT_OPAQUE_COST;
      use_over   = blend_cost <= {8'd0, rect_cost};
      rsp_data_in = '0;
      rsp_data_in[75:51] = s2_sum_ff.count;
      rsp_data_in[76]    = s2_sum_ff.opaque;
      if (any_change) begin
         rsp_data_in[0]      = 1'b1;
         rsp_data_in[12:1]   = s2_sum_ff.left;
         rsp_data_in[25:13]  = s2_sum_ff.right;
         rsp_data_in[37:26]  = s2_sum_ff.top;
         rsp_data_in[50:38]  = s2_sum_ff.bottom;
         rsp_data_in[100:77] = rect_cost;
         rsp_data_in[132:101] = blend_cost;
         rsp_data_in[133]    = use_over;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/fdcr_checker.sv -----
// ----------------------------------------------------------------------------
// fdcr_checker
// port-level checks of the frame difference change rectangle block
// ----------------------------------------------------------------------------
`include "frame_diff_change_rectangle_assert.svh"

module fdcr_checker
   import fdcr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [31:0]           csr_pwdata,
   input logic [31:0]           csr_prdata,
   input logic                  csr_pready
);

   `FDCR_ASSERT(a_pready_high, clock, reset, csr_pready, "pready low")

   `FDCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `FDCR_ASSERT(a_no_change_zero, clock, reset,
      !(rsp_tvalid && !rsp_tdata[0]) ||
      (rsp_tdata[75:1] == '0 && rsp_tdata[76] && rsp_tdata[135:77] == '0),
      "empty result carries data")

   `FDCR_ASSERT(a_rect_order, clock, reset,
      !(rsp_tvalid && rsp_tdata[0]) ||
      (rsp_tdata[25:13] > {1'b0, rsp_tdata[12:1]} &&
       rsp_tdata[50:38] > {1'b0, rsp_tdata[37:26]}),
      "rectangle edges out of order")

   `FDCR_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid,
      "result valid right after reset")

endmodule

bind frame_diff_change_rectangle fdcr_checker u_fdcr_checker (.*);

// ----- dv/change_rect_tracker_pkg.sv -----
// ----------------------------------------------------------------------------
// change_rect_tracker_pkg
// expected change rectangle and cost summaries for the testbench
// ----------------------------------------------------------------------------
// tracks the running change rectangle, count and opacity of the pixel pairs
// accepted by the block, and queues one summary per tlast beat. result beats
// are compared field by field against the oldest queued summary.
// ----------------------------------------------------------------------------
package change_rect_tracker_pkg;
   import fdcr_pkg::*;

   typedef struct packed {
      logic        any_change;
      logic [11:0] left;
      logic [12:0] right;
      logic [11:0] top;
      logic [12:0] bottom;
      logic [24:0] changed_count;
      logic        all_opaque;
      logic [23:0] rect_cost;
      logic [31:0] blend_cost;
      logic        use_over;
   } change_summary_t;

   class change_rect_tracker;
      logic [31:0]     mask;
      logic [12:0]     min_x;
      logic [12:0]     max_x;
      logic [12:0]     min_y;
      logic [12:0]     max_y;
      logic [24:0]     total;
      bit              opaque;
      change_summary_t summary_q[$];
      int              errors;

      function new();
         mask   = MASK_RESET;
         errors = 0;
         clear_region();
      endfunction

      function void clear_region();
         min_x  = 13'd4096;
         max_x  = 13'd0;
         min_y  = 13'd4096;
         max_y  = 13'd0;
         total  = '0;
         opaque = 1'b1;
      endfunction

      function void take_pair(logic [11:0] x, logic [11:0] y, logic [31:0] prev,
                              logic [31:0] cur, bit last);
         change_summary_t s;
         logic [63:0]     wid;
         logic [63:0]     hgt;
         logic [63:0]     cost;
         logic [31:0]     blend;
         if (((prev ^ cur) & mask) != 0) begin
            if ({1'b0, x} < min_x) min_x = {1'b0, x};
            if ({1'b0, y} < min_y) min_y = {1'b0, y};
            if ({1'b0, x} + 13'd1 > max_x) max_x = {1'b0, x} + 13'd1;
            if ({1'b0, y} + 13'd1 > max_y) max_y = {1'b0, y} + 13'd1;
            if (total != COUNT_MAX) total = total + 25'd1;
            if ((cur & ALPHA_MASK) != ALPHA_MASK) opaque = 1'b0;
         end
         if (!last) return;
         s     = '0;
         cost  = '0;
         blend = '0;
         s.any_change = (total != 0);
         if (s.any_change) begin
            s.left   = min_x[11:0];
            s.right  = max_x;
            s.top    = min_y[11:0];
            s.bottom = max_y;
            wid      = max_x - min_x;
            hgt      = max_y - min_y;
            cost     = wid * hgt - 64'd1;
            if (cost > COST_MAX) cost = COST_MAX;
            blend      = opaque ? 32'(total) : NOT_OPAQUE_COST;
            s.use_over = ({32'h0, blend} <= cost);
         end
         s.changed_count = total;
         s.all_opaque    = opaque;
         s.rect_cost     = cost[23:0];
         s.blend_cost    = blend;
         summary_q.push_back(s);
         clear_region();
      endfunction

      function void compare(string name, logic [63:0] expv, logic [63:0] actv);
         if (expv !== actv) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            errors++;
         end
      endfunction

      function void check_summary(logic [RSP_DATA_W-1:0] d);
         change_summary_t e;
         if (summary_q.size() == 0) begin
            $error("result beat with no expected summary");
            errors++;
            return;
         end
         e = summary_q.pop_front();
         compare("any_change", e.any_change, d[0]);
         compare("left", e.left, d[12:1]);
         compare("right", e.right, d[25:13]);
         compare("top", e.top, d[37:26]);
         compare("bottom", e.bottom, d[50:38]);
         compare("changed_count", e.changed_count, d[75:51]);
         compare("all_opaque", e.all_opaque, d[76]);
         compare("rect_cost", e.rect_cost, d[100:77]);
         compare("blend_cost", e.blend_cost, d[132:101]);
         compare("use_over", e.use_over, d[133]);
         compare("padding", 0, d[135:134]);
      endfunction
   endclass

endpackage

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// testbench of the frame difference change rectangle block
// ----------------------------------------------------------------------------
// streams scan regions of pixel pairs under several compare masks, first a
// few directed regions for corners, masked-out bits, repeats and opacity,
// then random regions. both stream sides idle at random. each result beat
// is checked against the tracker's expected summary.
// ----------------------------------------------------------------------------
module tb_top;
   import fdcr_pkg::*;
   import change_rect_tracker_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   change_rect_tracker tracker = new();
   bit                 idle_on = 1'b0;
   logic [31:0]        cur_mask = MASK_RESET;
   int                 pairs_sent = 0;

   frame_diff_change_rectangle dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int draw_gap();
      if (!idle_on || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 14);
   endfunction

   task automatic send_pair(input logic [11:0] x, input logic [11:0] y,
                            input logic [31:0] prev, input logic [31:0] cur,
                            input bit last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {cur, prev, y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      tracker.take_pair(x, y, prev, cur, last);
      pairs_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.summary_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ADDR_COMPARE_MASK;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mask(input logic [31:0] value);
      logic [31:0] rd;
      wait_drained();
      csr_access(1'b1, value, rd);
      csr_access(1'b0, '0, rd);
      tracker.mask = value;
      cur_mask     = value;
      tracker.compare("compare_mask", value, rd);
   endtask

   task automatic run_region();
      int          n;
      int          mode;
      int          p_change;
      int          w;
      int          x0;
      int          y0;
      bit          opaque_mode;
      logic [11:0] x;
      logic [11:0] y;
      logic [31:0] cur;
      logic [31:0] diff;
      n           = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
      mode        = $urandom_range(0, 2);
      p_change    = $urandom_range(0, 4) * 25;
      opaque_mode = ($urandom_range(0, 1) == 1);
      w           = $urandom_range(1, 8);
      x0          = $urandom_range(0, 4096 - 8);
      y0          = $urandom_range(0, 4096 - 41);
      for (int i = 0; i < n; i++) begin
         case (mode)
            0: begin
               x = 12'(x0 + i % w);
               y = 12'(y0 + i / w);
            end
            1: begin
               x = 12'($urandom_range(0, 4095));
               y = 12'($urandom_range(0, 4095));
            end
            default: begin
               x = 12'(x0 + $urandom_range(0, 1));
               y = 12'(y0 + $urandom_range(0, 1));
            end
         endcase
         if ($urandom_range(0, 99) < p_change) diff = $urandom;
         else if ($urandom_range(0, 1) == 0) diff = $urandom & ~cur_mask;
         else diff = '0;
         cur = $urandom;
         if (opaque_mode || $urandom_range(0, 3) == 0) cur[31:24] = 8'hff;
         send_pair(x, y, cur ^ diff, cur, i == n - 1);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_summary(rsp_tdata);
   end

   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      logic [31:0] rd;
      logic [31:0] masks [6];
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, '0, rd);
      tracker.compare("compare_mask", MASK_RESET, rd);

      // unchanged and masked-out differences
      send_pair(12'd0, 12'd0, 32'h0, 32'h0, 1'b1);
      send_pair(12'd7, 12'd3, 32'h0, 32'h00000001, 1'b1);
      send_pair(12'd3, 12'd3, 32'h0, 32'h00010101, 1'b1);
      // single changes at both corners
      send_pair(12'd0, 12'd0, 32'h0, 32'hffffffff, 1'b1);
      send_pair(12'd4095, 12'd4095, 32'hffffffff, 32'h0, 1'b1);
      idle_on = 1'b1;
      // full frame rectangle with two opaque changes
      send_pair(12'd0, 12'd0, 32'h0, 32'hff000000, 1'b0);
      send_pair(12'd4095, 12'd4095, 32'h12345678, 32'hff345678, 1'b0);
      send_pair(12'd100, 12'd200, 32'h5a5a5a5a, 32'h5a5a5a5a, 1'b1);
      // repeated coordinates
      repeat (3) send_pair(12'd5, 12'd5, 32'h0, 32'hff00ff00, 1'b0);
      send_pair(12'd5, 12'd5, 32'h0, 32'hff0000ff, 1'b1);
      // changes followed by an unchanged final pair
      send_pair(12'd10, 12'd20, 32'h0, 32'hffffff00, 1'b0);
      send_pair(12'd12, 12'd25, 32'h0, 32'hff00ff00, 1'b0);
      send_pair(12'd30, 12'd30, 32'h11111111, 32'h11111111, 1'b1);
      // opaque then translucent
      send_pair(12'd1, 12'd1, 32'h0, 32'hff000100, 1'b0);
      send_pair(12'd2, 12'd2, 32'h0, 32'hfe000100, 1'b1);

      masks[0] = 32'hffffffff;
      masks[1] = 32'h0;
      masks[2] = ALPHA_MASK;
      masks[3] = $urandom;
      masks[4] = $urandom;
      masks[5] = MASK_RESET;
      for (int phase = 0; phase < 7; phase++) begin
         if (phase > 0) set_mask(masks[phase - 1]);
         pairs_sent = 0;
         while (pairs_sent < 160) begin
            idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
            run_region();
            if ($urandom_range(0, 9) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
